>>> rtl/gla_pkg.sv
package gla_pkg;

   // Field widths fixed by the request and response formats
   localparam int CountWidth = 9;
   localparam int PenWidth   = 24;

   // Request function codes
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_PLACE = 2'd1;
   localparam logic [1:0] FUNC_PEN   = 2'd2;

   localparam logic signed [PenWidth-1:0] PEN_MAX = 24'sh7FFFFF;
   localparam logic signed [PenWidth-1:0] PEN_MIN = 24'sh800000;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         slot;
      logic [7:0]         glyph_size;
      logic [7:0]         char_code;
      logic signed [15:0] left_bearing;
      logic signed [15:0] top_bearing;
      logic signed [15:0] advance;
      logic [9:0]         img_width;
      logic [9:0]         img_height;
      logic [15:0]        texture_id;
      logic signed [23:0] pen_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [7:0]         found_slot;
      logic signed [23:0] quad_x;
      logic signed [15:0] quad_y;
      logic [9:0]         quad_width;
      logic [9:0]         quad_height;
      logic [15:0]        quad_texture;
      logic signed [23:0] pen_position;
   } rsp_type;

   // One glyph table entry
   typedef struct packed {
      logic [7:0]         size;
      logic [7:0]         code;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] adv;
      logic [9:0]         width;
      logic [9:0]         height;
      logic [15:0]        tex;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic load;          // capture request, init search bounds
      logic mem_write;     // write table entry
      logic pen_set;       // load pen from request
      logic respond_plain; // issue a no-glyph response
      logic rd_mid;        // read probe entry
      logic rd_first;      // read lower-bound entry
      logic step;          // narrow search range
      logic finish;        // evaluate hit, respond, advance pen
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] func;
      logic       len_zero;
   } status_type;

   // Saturate a 25-bit sum into the 24-bit pen range
   function automatic logic [PenWidth-1:0] sat_pen(input logic [PenWidth:0] sum);
      logic [PenWidth-1:0] res;
      if (sum[PenWidth] != sum[PenWidth-1]) begin
         res = sum[PenWidth] ? PEN_MIN : PEN_MAX;
      end else begin
         res = sum[PenWidth-1:0];
      end
      return res;
   endfunction

endpackage

>>> rtl/gla_ctrl.sv
module gla_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  gla_pkg::status_type status,
   output gla_pkg::cmd_type    cmd
);
   import gla_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_PROBE  = 5'b00100,
      ST_STEP   = 5'b01000,
      ST_FINAL  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.func)
               FUNC_WRITE: begin
                  cmd.mem_write     = 1'b1;
                  cmd.respond_plain = 1'b1;
                  state_in          = ST_IDLE;
               end
               FUNC_PEN: begin
                  cmd.pen_set       = 1'b1;
                  cmd.respond_plain = 1'b1;
                  state_in          = ST_IDLE;
               end
               FUNC_PLACE: begin
                  state_in = ST_PROBE;
               end
               default: begin
                  cmd.respond_plain = 1'b1;
                  state_in          = ST_IDLE;
               end
            endcase
         end
         ST_PROBE: begin
            if (status.len_zero) begin
               cmd.rd_first = 1'b1;
               state_in     = ST_FINAL;
            end else begin
               cmd.rd_mid = 1'b1;
               state_in   = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_PROBE;
         end
         ST_FINAL: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef ASSERT_OFF
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");
   a_step_then_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |=> (state_ff == ST_PROBE))
      else $error("search step not followed by probe");
   a_final_then_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |=> !busy)
      else $error("final step did not return to idle");
`endif

endmodule

>>> rtl/gla_datapath.sv
module gla_datapath #(
   parameter int GLYPH_SLOTS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gla_pkg::req_type                      req_data,
   input  logic                                  csr_write_en,
   input  logic [gla_pkg::CountWidth-1:0]        csr_write_data,
   input  gla_pkg::cmd_type                      cmd,
   output gla_pkg::status_type                   status,
   output logic                                  rsp_strobe,
   output gla_pkg::rsp_type                      rsp_data
);
   import gla_pkg::*;

   localparam int AddrWidth = $clog2(GLYPH_SLOTS);

   // Glyph table
   entry_type mem [GLYPH_SLOTS];

   req_type                req_ff;
   logic [CountWidth-1:0]  count_ff;
   logic [CountWidth-1:0]  n_ff;
   logic [CountWidth-1:0]  first_ff, first_in;
   logic [CountWidth-1:0]  len_ff, len_in;
   logic [PenWidth-1:0]    pen_ff, pen_in;
   entry_type              rd_ff;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_strobe_ff;

   logic [CountWidth-1:0]  n_clip;
   logic [CountWidth-1:0]  half;
   logic [CountWidth-1:0]  mid;
   logic [AddrWidth-1:0]   rd_addr;
   logic                   slot_ok;
   logic                   key_less;
   logic                   hit;
   logic [PenWidth:0]      qx_sum;
   logic [PenWidth:0]      adv_sum;
   entry_type              wr_entry;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_en) begin
         count_ff <= csr_write_data;
      end
   end

   // Entry count clipped to table depth
   assign n_clip = (32'(count_ff) > GLYPH_SLOTS) ? CountWidth'(GLYPH_SLOTS) : count_ff;

   // Search bookkeeping
   assign half     = len_ff >> 1;
   assign mid      = first_ff + half;
   assign key_less = (rd_ff.size < req_ff.glyph_size) ||
                     ((rd_ff.size == req_ff.glyph_size) && (rd_ff.code < req_ff.char_code));

   always_comb begin
      first_in = first_ff;
      len_in   = len_ff;
      if (cmd.load) begin
         first_in = '0;
         len_in   = n_clip;
      end else if (cmd.step) begin
         if (key_less) begin
            first_in = mid + CountWidth'(1);
            len_in   = len_ff - half - CountWidth'(1);
         end else begin
            len_in = half;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      len_ff   <= len_in;
      if (cmd.load) begin
         req_ff <= req_data;
         n_ff   <= n_clip;
      end
   end

   assign status.func     = req_ff.func;
   assign status.len_zero = (len_ff == '0);

   // Table write and registered read
   assign slot_ok = (32'(req_ff.slot) < GLYPH_SLOTS);
   assign rd_addr = cmd.rd_mid ? AddrWidth'(mid) : AddrWidth'(first_ff);

   always_comb begin
      wr_entry.size   = req_ff.glyph_size;
      wr_entry.code   = req_ff.char_code;
      wr_entry.left   = req_ff.left_bearing;
      wr_entry.top    = req_ff.top_bearing;
      wr_entry.adv    = req_ff.advance;
      wr_entry.width  = req_ff.img_width;
      wr_entry.height = req_ff.img_height;
      wr_entry.tex    = req_ff.texture_id;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write && slot_ok) begin
         mem[AddrWidth'(req_ff.slot)] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_mid || cmd.rd_first) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Hit check and pen arithmetic
   assign hit = (first_ff < n_ff) && (rd_ff.size == req_ff.glyph_size) &&
                (rd_ff.code == req_ff.char_code);
   assign qx_sum  = {pen_ff[PenWidth-1], pen_ff} +
                    {{(PenWidth-15){rd_ff.left[15]}}, rd_ff.left};
   assign adv_sum = {pen_ff[PenWidth-1], pen_ff} +
                    {{(PenWidth-15){rd_ff.adv[15]}}, rd_ff.adv};

   always_comb begin
      pen_in = pen_ff;
      if (cmd.pen_set) begin
         pen_in = req_ff.pen_value;
      end else if (cmd.finish && hit) begin
         pen_in = sat_pen(adv_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff <= '0;
      end else begin
         pen_ff <= pen_in;
      end
   end

   // Response register
   always_comb begin
      rsp_in              = '0;
      rsp_in.pen_position = pen_in;
      if (cmd.finish && hit) begin
         rsp_in.found        = 1'b1;
         rsp_in.found_slot   = first_ff[7:0];
         rsp_in.quad_x       = sat_pen(qx_sum);
         rsp_in.quad_y       = (rd_ff.top == 16'sh8000) ? 16'sh7FFF : -rd_ff.top;
         rsp_in.quad_width   = rd_ff.width;
         rsp_in.quad_height  = rd_ff.height;
         rsp_in.quad_texture = rd_ff.tex;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish || cmd.respond_plain) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish || cmd.respond_plain;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef ASSERT_OFF
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (32'(first_ff) + 32'(len_ff) <= 32'(n_ff)))
      else $error("search window exceeds entry count");
   a_pen_hold_on_miss: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !hit) |=> (pen_ff == $past(pen_ff)))
      else $error("pen moved on a miss");
   a_one_read_per_probe: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_mid && cmd.rd_first))
      else $error("two reads issued at once");
`endif

endmodule

>>> rtl/glyph_lookup_and_advance_top.sv
// Glyph lookup and pen advance. Pulse start with a request while busy is low;
// busy stays high until the request is done and exactly one response appears
// on rsp_data for a single cycle, marked by rsp_strobe. The receiver cannot
// stall, so capture rsp_data whenever rsp_strobe is high. A table write, pen
// set or unused function is answered from the decode state. A placement runs
// P binary-search probes, where P is at most ceil(log2(n+1)) for n valid
// entries, so 9 for 256 entries: each probe is one table read with
// registered data followed by a compare step, and one more read of the
// lower-bound entry comes before the hit check. A new request may start in
// the cycle the previous response is shown. csr_write_en/csr_write_data load
// the valid entry count; write it only while idle.
module glyph_lookup_and_advance_top #(
   parameter int GLYPH_SLOTS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  gla_pkg::req_type               req_data,
   output logic                           rsp_strobe,
   output gla_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [gla_pkg::CountWidth-1:0] csr_write_data
);
   import gla_pkg::*;

   cmd_type    cmd;
   status_type status;

   gla_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   gla_datapath #(
      .GLYPH_SLOTS (GLYPH_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data)
   );

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response strobes");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while still busy");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.found) |->
         (rsp_data.quad_x == '0 && rsp_data.quad_texture == '0 &&
          rsp_data.found_slot == '0))
      else $error("miss response carries glyph data");
`endif

endmodule
